FILE: rtl/core/mcmg_pkg.sv
// Shared types, constants and reset tables of the multi-channel modulation generator.
package mcmg_pkg;

    localparam int N_CHANNELS = 9;
    localparam int CH_W = 4;
    localparam int AMP_W = 16;
    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int PERIOD_WIDTH_DEF = 16;

    localparam logic [CH_W-1:0] CH_PUMP_X = 4'd0;
    localparam logic [CH_W-1:0] CH_PUMP_Y = 4'd1;
    localparam logic [CH_W-1:0] CH_FREE_0 = 4'd2;
    localparam logic [CH_W-1:0] CH_FREE_1 = 4'd3;
    localparam logic [CH_W-1:0] CH_BX = 4'd4;
    localparam logic [CH_W-1:0] CH_BY = 4'd5;
    localparam logic [CH_W-1:0] CH_PUMP_0 = 4'd6;
    localparam logic [CH_W-1:0] CH_PUMP_1 = 4'd7;
    localparam logic [CH_W-1:0] CH_TABLE = 4'd8;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;
    localparam logic [30:0] POLY_C0 = 31'd172272;

    typedef enum logic [1:0] {
        REQ_TICK       = 2'd0,
        REQ_SET_PERIOD = 2'd1,
        REQ_SET_AMP    = 2'd2,
        REQ_ZERO_PHASE = 2'd3
    } req_t;

    function automatic logic [31:0] period_reset(input logic [CH_W-1:0] ch);
        case (ch)
            CH_PUMP_X: period_reset = 32'd4096;
            CH_PUMP_Y: period_reset = 32'd3072;
            CH_FREE_0: period_reset = 32'd47;
            CH_FREE_1: period_reset = 32'd37;
            CH_BX:     period_reset = 32'd1231;
            CH_BY:     period_reset = 32'd1082;
            CH_PUMP_0: period_reset = 32'd1231;
            CH_PUMP_1: period_reset = 32'd1082;
            CH_TABLE:  period_reset = 32'd2560;
            default:   period_reset = 32'd1;
        endcase
    endfunction

    function automatic logic signed [AMP_W-1:0] amp_reset(input logic [CH_W-1:0] ch);
        case (ch)
            CH_FREE_0: amp_reset = 16'sd500;
            CH_FREE_1: amp_reset = 16'sd500;
            default:   amp_reset = 16'sd0;
        endcase
    endfunction

    function automatic logic is_square(input logic [CH_W-1:0] ch);
        case (ch)
            CH_PUMP_X, CH_PUMP_Y, CH_BX, CH_BY, CH_TABLE: is_square = 1'b1;
            default: is_square = 1'b0;
        endcase
    endfunction

    function automatic logic [30:0] poly_coef(input logic [2:0] step);
        case (step)
            3'd1:    poly_coef = 31'd5026995;
            3'd2:    poly_coef = 31'd85569306;
            3'd3:    poly_coef = 31'd693598668;
            3'd4:    poly_coef = 31'd1686629713;
            default: poly_coef = 31'd0;
        endcase
    endfunction

endpackage

FILE: rtl/core/mcmg_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module mcmg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 9
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/mcmg_sine.sv
// Sine unit: serial phase divider and a shared multiplier for the Q30 polynomial.
module mcmg_sine
    import mcmg_pkg::*;
#(
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF,
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [PERIOD_WIDTH-1:0] count,
    input  logic [PERIOD_WIDTH-1:0] period,
    output logic                    done,
    output logic signed [31:0]      value
);

    localparam int PW = PERIOD_WIDTH;
    localparam int AW = $clog2(SINE_TABLE_DEPTH);
    localparam int SCW = $clog2(AW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_PREP,
        S_MUL,
        S_ACC
    } state_t;

    state_t             state_reg;
    logic [PW:0]        rem_reg;
    logic [PW-1:0]      per_reg;
    logic [AW-1:0]      quo_reg;
    logic [SCW-1:0]     bit_cnt_reg;
    logic [30:0]        u_reg;
    logic [30:0]        u2_reg;
    logic [30:0]        t_reg;
    logic [61:0]        prod_reg;
    logic [2:0]         step_reg;
    logic               neg_reg;
    logic               done_reg;
    logic signed [31:0] value_reg;

    logic [PW:0]   rem_shift;
    logic          rem_ge;
    logic [PW:0]   rem_next;
    logic [1:0]    quad;
    logic [30:0]   u_raw;
    logic [30:0]   u_next;
    logic [30:0]   mul_a;
    logic [30:0]   mul_b;
    logic [31:0]   prod_sh;
    logic [30:0]   s_clamp;

    always_comb
    begin
        rem_shift = {rem_reg[PW-1:0], 1'b0};
        rem_ge = rem_shift >= {1'b0, per_reg};
        rem_next = rem_ge ? (rem_shift - {1'b0, per_reg}) : rem_shift;
        quad = quo_reg[AW-1:AW-2];
        u_raw = 31'({quo_reg[AW-3:0], {(32 - AW){1'b0}}});
        u_next = quad[0] ? (Q30_ONE - u_raw) : u_raw;
        mul_a = (step_reg == 3'd0 || step_reg == 3'd5) ? u_reg : u2_reg;
        mul_b = (step_reg == 3'd0) ? u_reg : t_reg;
        prod_sh = prod_reg[61:30];
        s_clamp = (prod_sh > 32'(Q30_ONE)) ? Q30_ONE : prod_sh[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rem_reg <= '0;
            per_reg <= '0;
            quo_reg <= '0;
            bit_cnt_reg <= '0;
            u_reg <= '0;
            u2_reg <= '0;
            t_reg <= '0;
            prod_reg <= '0;
            step_reg <= '0;
            neg_reg <= 1'b0;
            done_reg <= 1'b0;
            value_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        rem_reg <= {1'b0, count};
                        per_reg <= period;
                        quo_reg <= '0;
                        bit_cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[AW-2:0], rem_ge};
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == SCW'(AW - 1))
                    begin
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    u_reg <= u_next;
                    neg_reg <= quad[1];
                    step_reg <= 3'd0;
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    prod_reg <= 62'(mul_a * mul_b);
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    step_reg <= step_reg + 3'd1;
                    state_reg <= S_MUL;
                    if (step_reg == 3'd0)
                    begin
                        u2_reg <= prod_sh[30:0];
                        t_reg <= POLY_C0;
                    end
                    else if (step_reg == 3'd5)
                    begin
                        value_reg <= neg_reg ? -$signed({1'b0, s_clamp})
                                             : $signed({1'b0, s_clamp});
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        t_reg <= 31'({1'b0, poly_coef(step_reg)} - prod_sh);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign value = value_reg;

endmodule

FILE: rtl/core/multi_channel_modulation_generator.sv
// Top level of the nine-channel modulation generator: request sequencer and channel store.
//
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------------------
//  request   start / busy              req_type, channel, period_value, amp_value
//  result    done (one-cycle strobe)   pump_x_offset, pump_y_offset, table_offset,
//                                      dac0_free, dac1_free, dac0_pumping, dac1_pumping
//  config    cfg_valid / cfg_ready     cfg_data (enable)
//
// An enabled tick holds busy through the whole channel sweep, with done in the first cycle
// after busy falls. Its length is set by the serial phase divider and the shared polynomial
// multiplier in the sine unit, which run once per sine channel.
// Set period and set amplitude hold busy for a store read and a write; zero phases, a
// disabled tick and a set request for a channel out of range complete in the accepting cycle.
// Reset restores all channel state at once.
// The receiver cannot stall, so each result transaction lasts exactly one cycle.
module multi_channel_modulation_generator
    import mcmg_pkg::*;
#(
    parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
    parameter int PERIOD_WIDTH = PERIOD_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          req_type,
    input  logic [3:0]          channel,
    input  logic [15:0]         period_value,
    input  logic signed [15:0]  amp_value,
    output logic                done,
    output logic signed [15:0]  pump_x_offset,
    output logic signed [15:0]  pump_y_offset,
    output logic signed [15:0]  table_offset,
    output logic signed [16:0]  dac0_free,
    output logic signed [16:0]  dac1_free,
    output logic signed [17:0]  dac0_pumping,
    output logic signed [17:0]  dac1_pumping,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    localparam int PW = PERIOD_WIDTH;
    localparam int RAM_W = 2 * PW + AMP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_UPD,
        S_SQ,
        S_SST,
        S_SWAIT,
        S_MAC,
        S_ACC,
        S_OUT
    } state_t;

    state_t                  state_reg;
    req_t                    op_reg;
    logic [CH_W-1:0]         ch_reg;
    logic                    enable_reg;
    logic [N_CHANNELS-1:0]   phase_vld_reg;
    logic [N_CHANNELS-1:0]   per_vld_reg;
    logic [N_CHANNELS-1:0]   amp_vld_reg;
    logic [PW-1:0]           new_per_reg;
    logic signed [15:0]      new_amp_reg;
    logic [PW-1:0]           cnt_reg;
    logic [PW-1:0]           per_reg;
    logic signed [15:0]      amp_reg;
    logic signed [47:0]      mac_reg;
    logic signed [15:0]      bx_prev_reg;
    logic signed [15:0]      by_prev_reg;
    logic signed [15:0]      px_reg;
    logic signed [15:0]      py_reg;
    logic signed [15:0]      tab_reg;
    logic signed [16:0]      f0_reg;
    logic signed [16:0]      f1_reg;
    logic signed [16:0]      n0_reg;
    logic signed [16:0]      n1_reg;
    logic signed [17:0]      p0_reg;
    logic signed [17:0]      p1_reg;
    logic                    done_reg;

    logic                    ram_we;
    logic                    ram_re;
    logic [RAM_W-1:0]        ram_wdata;
    logic [RAM_W-1:0]        ram_rdata;

    logic                    sine_start;
    logic                    sine_done;
    logic signed [31:0]      sine_val;

    logic                    accept;
    logic [PW-1:0]           in_per;
    logic [PW-1:0]           per_rst;
    logic [PW-1:0]           cur_phase;
    logic [PW-1:0]           cur_per;
    logic signed [15:0]      cur_amp;
    logic [PW:0]             phase_inc;
    logic [PW-1:0]           phase_next;
    logic signed [15:0]      sq_val;
    logic signed [15:0]      prev_sel;
    logic signed [48:0]      acc_v;
    logic signed [48:0]      acc_q;
    logic                    acc_corr;
    logic signed [16:0]      trunc_v;

    assign accept = start && !busy;

    always_comb
    begin
        in_per = PW'(period_value);
        if (in_per == '0)
        begin
            in_per = PW'(1);
        end
        per_rst = PW'(period_reset(ch_reg));
        if (per_rst == '0)
        begin
            per_rst = PW'(1);
        end
        cur_phase = phase_vld_reg[ch_reg] ? ram_rdata[RAM_W-1 -: PW] : '0;
        cur_per = per_vld_reg[ch_reg] ? ram_rdata[PW+AMP_W-1 -: PW] : per_rst;
        cur_amp = amp_vld_reg[ch_reg] ? $signed(ram_rdata[AMP_W-1:0]) : amp_reset(ch_reg);
        phase_inc = {1'b0, cur_phase} + 1'b1;
        phase_next = (phase_inc >= {1'b0, cur_per}) ? '0 : phase_inc[PW-1:0];
        case (op_reg)
            REQ_SET_PERIOD: ram_wdata = {cur_phase, new_per_reg, cur_amp};
            REQ_SET_AMP:    ram_wdata = {cur_phase, cur_per, new_amp_reg};
            default:        ram_wdata = {phase_next, cur_per, cur_amp};
        endcase
        ram_re = (state_reg == S_RD);
        ram_we = (state_reg == S_UPD);
        sine_start = (state_reg == S_SST);
        sq_val = ({cnt_reg, 1'b0} < {1'b0, per_reg}) ? amp_reg : -amp_reg;
        case (ch_reg)
            CH_FREE_0: prev_sel = bx_prev_reg;
            CH_FREE_1: prev_sel = by_prev_reg;
            default:   prev_sel = 16'sd0;
        endcase
        acc_v = 49'(mac_reg) + 49'($signed({prev_sel, 30'd0}));
        acc_q = acc_v >>> 30;
        acc_corr = acc_v[48] && (acc_v[29:0] != 30'd0);
        trunc_v = 17'(acc_q + 49'(acc_corr));
    end

    mcmg_ram #(
        .WIDTH(RAM_W),
        .DEPTH(N_CHANNELS)
    ) u_chan_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ch_reg),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ch_reg),
        .rdata(ram_rdata)
    );

    mcmg_sine #(
        .PERIOD_WIDTH(PERIOD_WIDTH),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sine (
        .clk(clk),
        .rst_n(rst_n),
        .start(sine_start),
        .count(cnt_reg),
        .period(per_reg),
        .done(sine_done),
        .value(sine_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= REQ_TICK;
            ch_reg <= '0;
            enable_reg <= 1'b1;
            phase_vld_reg <= '0;
            per_vld_reg <= '0;
            amp_vld_reg <= '0;
            new_per_reg <= '0;
            new_amp_reg <= '0;
            cnt_reg <= '0;
            per_reg <= '0;
            amp_reg <= '0;
            mac_reg <= '0;
            bx_prev_reg <= '0;
            by_prev_reg <= '0;
            px_reg <= '0;
            py_reg <= '0;
            tab_reg <= '0;
            f0_reg <= '0;
            f1_reg <= '0;
            n0_reg <= '0;
            n1_reg <= '0;
            p0_reg <= '0;
            p1_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg <= req_t'(req_type);
                        new_per_reg <= in_per;
                        new_amp_reg <= (amp_value == -16'sd32768) ? -16'sd32767 : amp_value;
                        case (req_t'(req_type))
                            REQ_TICK:
                            begin
                                if (enable_reg)
                                begin
                                    ch_reg <= '0;
                                    state_reg <= S_RD;
                                end
                            end
                            REQ_ZERO_PHASE:
                            begin
                                phase_vld_reg <= '0;
                                enable_reg <= 1'b1;
                            end
                            default:
                            begin
                                if (channel < CH_W'(N_CHANNELS))
                                begin
                                    ch_reg <= channel;
                                    state_reg <= S_RD;
                                end
                            end
                        endcase
                    end
                end
                S_RD:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    phase_vld_reg[ch_reg] <= 1'b1;
                    per_vld_reg[ch_reg] <= 1'b1;
                    amp_vld_reg[ch_reg] <= 1'b1;
                    cnt_reg <= phase_next;
                    per_reg <= cur_per;
                    amp_reg <= cur_amp;
                    if (op_reg == REQ_TICK)
                    begin
                        state_reg <= is_square(ch_reg) ? S_SQ : S_SST;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SQ:
                begin
                    case (ch_reg)
                        CH_PUMP_X: px_reg <= sq_val;
                        CH_PUMP_Y: py_reg <= sq_val;
                        CH_BX:     bx_prev_reg <= sq_val;
                        CH_BY:     by_prev_reg <= sq_val;
                        default:   tab_reg <= sq_val;
                    endcase
                    if (ch_reg == CH_W'(N_CHANNELS - 1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                end
                S_SST:
                begin
                    state_reg <= S_SWAIT;
                end
                S_SWAIT:
                begin
                    if (sine_done)
                    begin
                        state_reg <= S_MAC;
                    end
                end
                S_MAC:
                begin
                    mac_reg <= amp_reg * sine_val;
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    case (ch_reg)
                        CH_FREE_0: f0_reg <= trunc_v;
                        CH_FREE_1: f1_reg <= trunc_v;
                        CH_PUMP_0: n0_reg <= trunc_v;
                        default:   n1_reg <= trunc_v;
                    endcase
                    ch_reg <= ch_reg + 1'b1;
                    state_reg <= S_RD;
                end
                S_OUT:
                begin
                    p0_reg <= 18'(f0_reg) + 18'(n0_reg);
                    p1_reg <= 18'(f1_reg) + 18'(n1_reg);
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (cfg_valid && cfg_ready)
            begin
                enable_reg <= cfg_data;
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done = done_reg;
    assign pump_x_offset = px_reg;
    assign pump_y_offset = py_reg;
    assign table_offset = tab_reg;
    assign dac0_free = f0_reg;
    assign dac1_free = f1_reg;
    assign dac0_pumping = p0_reg;
    assign dac1_pumping = p1_reg;

`ifndef SYNTHESIS
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == S_OUT))
        else $error("result strobe without a finished tick");

    a_upd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPD) |-> (ch_reg < CH_W'(N_CHANNELS)))
        else $error("channel store written beyond the last channel");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("channel store read and written in the same cycle");

    a_sine_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sine_done |-> (state_reg == S_SWAIT))
        else $error("sine result arrived outside the wait state");
`endif

endmodule

FILE: tb/sv/tb_multi_channel_modulation_generator.sv
`timescale 1ns / 1ps
// Self-checking testbench of the multi-channel modulation generator with a built-in channel model.
module tb_multi_channel_modulation_generator;
    import mcmg_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int DEPTH = SINE_TABLE_DEPTH_DEF;
    localparam int TICK_LATENCY = 4 * $clog2(DEPTH) + 92;
    localparam int SETTLE_CYCLES = TICK_LATENCY + 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam longint CYCLE_LIMIT = 1200000;
    localparam longint Q30 = 64'sd1073741824;

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] tab;
        logic signed [16:0] f0;
        logic signed [16:0] f1;
        logic signed [17:0] p0;
        logic signed [17:0] p1;
    } mod_result_t;

    typedef struct {
        bit          is_cfg;
        req_t        req;
        logic [3:0]  ch;
        logic [15:0] per;
        logic [15:0] amp;
        bit          typed;
        mod_result_t want;
    } stim_row_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         req_type;
    logic [3:0]         channel;
    logic [15:0]        period_value;
    logic signed [15:0] amp_value;
    logic               done;
    logic signed [15:0] pump_x_offset;
    logic signed [15:0] pump_y_offset;
    logic signed [15:0] table_offset;
    logic signed [16:0] dac0_free;
    logic signed [16:0] dac1_free;
    logic signed [17:0] dac0_pumping;
    logic signed [17:0] dac1_pumping;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_data;

    logic [15:0]        ph_cnt [N_CHANNELS];
    logic [15:0]        ch_period [N_CHANNELS];
    logic signed [15:0] ch_amp [N_CHANNELS];
    longint             bx_prev;
    longint             by_prev;
    bit                 gen_enable;

    mod_result_t pending_outputs [$];
    stim_row_t   directed_rows [$];
    int          mismatch_count;
    longint      cycle_count;
    int          burst_left;
    bit          steady_phase;

    multi_channel_modulation_generator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .channel       (channel),
        .period_value  (period_value),
        .amp_value     (amp_value),
        .done          (done),
        .pump_x_offset (pump_x_offset),
        .pump_y_offset (pump_y_offset),
        .table_offset  (table_offset),
        .dac0_free     (dac0_free),
        .dac1_free     (dac1_free),
        .dac0_pumping  (dac0_pumping),
        .dac1_pumping  (dac1_pumping),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic longint sine_fix(input longint unsigned cnt, input longint unsigned per);
        longint unsigned p, idx, q4, quad, u, u2, t, s;
        p = (per == 0) ? 1 : per;
        idx = (cnt * DEPTH) / p;
        if (idx >= DEPTH)
            idx = DEPTH - 1;
        q4 = idx * 4;
        quad = q4 / DEPTH;
        u = ((q4 % DEPTH) << 30) / DEPTH;
        if (quad[0])
            u = Q30 - u;
        u2 = (u * u) >> 30;
        t = 172272;
        t = 5026995 - ((u2 * t) >> 30);
        t = 85569306 - ((u2 * t) >> 30);
        t = 693598668 - ((u2 * t) >> 30);
        t = 1686629713 - ((u2 * t) >> 30);
        s = (u * t) >> 30;
        if (s > Q30)
            s = Q30;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    function automatic void step_channel(input int c);
        logic [16:0] nxt;
        nxt = ph_cnt[c] + 17'd1;
        if (nxt >= {1'b0, ch_period[c]})
            nxt = '0;
        ph_cnt[c] = nxt[15:0];
    endfunction

    function automatic longint square_of(input int c);
        if ({ph_cnt[c], 1'b0} < {1'b0, ch_period[c]})
            return longint'(ch_amp[c]);
        return -longint'(ch_amp[c]);
    endfunction

    function automatic longint sine_of(input int c);
        return longint'(ch_amp[c]) * sine_fix(longint'(ph_cnt[c]), longint'(ch_period[c]));
    endfunction

    function automatic void reset_channels();
        for (int c = 0; c < N_CHANNELS; c++)
        begin
            ph_cnt[c] = '0;
            ch_period[c] = 16'(period_reset(c[CH_W-1:0]));
            ch_amp[c] = amp_reset(c[CH_W-1:0]);
        end
        bx_prev = 0;
        by_prev = 0;
        gen_enable = 1'b1;
    endfunction

    // Applies one request to the channel model; returns 1 when the request yields a result.
    function automatic bit predict_request(input req_t rq, input logic [3:0] c,
                                           input logic [15:0] per, input logic signed [15:0] amp,
                                           output mod_result_t res);
        longint px, py, tab, f0, f1, n0, n1, s0, s1;
        bit produced;
        res = '0;
        produced = 1'b0;
        if (rq == REQ_SET_PERIOD)
        begin
            if (c < N_CHANNELS)
                ch_period[c] = (per == 16'd0) ? 16'd1 : per;
        end
        else if (rq == REQ_SET_AMP)
        begin
            if (c < N_CHANNELS)
                ch_amp[c] = (amp == -16'sd32768) ? -16'sd32767 : amp;
        end
        else if (rq == REQ_ZERO_PHASE)
        begin
            for (int k = 0; k < N_CHANNELS; k++)
                ph_cnt[k] = '0;
            gen_enable = 1'b1;
        end
        else if (gen_enable)
        begin
            step_channel(0);
            px = square_of(0);
            step_channel(1);
            py = square_of(1);
            step_channel(2);
            f0 = (sine_of(2) + bx_prev * Q30) / Q30;
            step_channel(3);
            f1 = (sine_of(3) + by_prev * Q30) / Q30;
            step_channel(4);
            bx_prev = square_of(4);
            step_channel(5);
            by_prev = square_of(5);
            step_channel(6);
            n0 = sine_of(6) / Q30;
            step_channel(7);
            n1 = sine_of(7) / Q30;
            step_channel(8);
            tab = square_of(8);
            s0 = f0 + n0;
            s1 = f1 + n1;
            res.px = px[15:0];
            res.py = py[15:0];
            res.tab = tab[15:0];
            res.f0 = f0[16:0];
            res.f1 = f1[16:0];
            res.p0 = s0[17:0];
            res.p1 = s1[17:0];
            produced = 1'b1;
        end
        return produced;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        mod_result_t want;
        if (rst_n && done)
        begin
            if (pending_outputs.size() == 0)
            begin
                $error("result transaction with no tick outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_outputs.pop_front();
                check_field("pump_x_offset", longint'(want.px), longint'(pump_x_offset));
                check_field("pump_y_offset", longint'(want.py), longint'(pump_y_offset));
                check_field("table_offset", longint'(want.tab), longint'(table_offset));
                check_field("dac0_free", longint'(want.f0), longint'(dac0_free));
                check_field("dac1_free", longint'(want.f1), longint'(dac1_free));
                check_field("dac0_pumping", longint'(want.p0), longint'(dac0_pumping));
                check_field("dac1_pumping", longint'(want.p1), longint'(dac1_pumping));
            end
        end
    end

    task automatic send_request(input req_t rq, input logic [3:0] c, input logic [15:0] per,
                                input logic [15:0] amp, input bit typed, input mod_result_t want);
        mod_result_t got;
        start <= 1'b1;
        req_type <= rq;
        channel <= c;
        period_value <= per;
        amp_value <= amp;
        do @(posedge clk); while (busy);
        if (predict_request(rq, c, per, amp, got))
            pending_outputs.push_back(typed ? want : got);
    endtask

    task automatic maybe_pause();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 160) : $urandom_range(0, 6);
        if (steady_phase)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Waits until no tick is in flight, then writes the enable register.
    task automatic settle_and_configure(input bit en);
        start <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= en;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_enable = en;
    endtask

    task automatic add_row(input req_t rq, input logic [3:0] c, input logic [15:0] per,
                           input logic [15:0] amp);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.req = rq;
        r.ch = c;
        r.per = per;
        r.amp = amp;
        r.typed = 1'b0;
        r.want = '0;
        directed_rows.push_back(r);
    endtask

    task automatic add_typed_tick(input int px, input int py, input int tab, input int f0,
                                  input int f1, input int p0, input int p1);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.req = REQ_TICK;
        r.ch = '0;
        r.per = '0;
        r.amp = '0;
        r.typed = 1'b1;
        r.want.px = px[15:0];
        r.want.py = py[15:0];
        r.want.tab = tab[15:0];
        r.want.f0 = f0[16:0];
        r.want.f1 = f1[16:0];
        r.want.p0 = p0[17:0];
        r.want.p1 = p1[17:0];
        directed_rows.push_back(r);
    endtask

    task automatic add_cfg_row(input bit en);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.req = REQ_TICK;
        r.ch = '0;
        r.per = {15'd0, en};
        r.amp = '0;
        r.typed = 1'b0;
        r.want = '0;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed();
        add_typed_tick(0, 0, 0, 64, 82, 64, 82);
        add_row(REQ_SET_AMP, CH_FREE_0, 16'd0, 16'h0000);
        add_row(REQ_SET_AMP, CH_FREE_1, 16'd0, 16'h0000);
        add_row(REQ_SET_AMP, CH_PUMP_X, 16'd0, 16'h8000);
        add_row(REQ_SET_AMP, CH_PUMP_Y, 16'd0, 16'h7FFF);
        add_row(REQ_SET_AMP, CH_TABLE, 16'd0, 16'h8001);
        add_typed_tick(-32767, 32767, -32767, 0, 0, 0, 0);
        add_row(REQ_SET_PERIOD, CH_PUMP_X, 16'd0, 16'h0000);
        add_row(REQ_SET_PERIOD, CH_PUMP_Y, 16'd3, 16'h0000);
        add_typed_tick(-32767, 32767, -32767, 0, 0, 0, 0);
        add_row(REQ_SET_AMP, CH_BX, 16'd0, 16'h7FFF);
        add_row(REQ_SET_AMP, CH_BY, 16'd0, 16'h8001);
        add_typed_tick(-32767, 32767, -32767, 0, 0, 0, 0);
        add_typed_tick(-32767, -32767, -32767, 32767, -32767, 32767, -32767);
        add_row(REQ_SET_AMP, CH_PUMP_0, 16'd0, 16'h7FFF);
        add_row(REQ_SET_AMP, CH_PUMP_1, 16'd0, 16'h8000);
        add_row(REQ_SET_PERIOD, CH_FREE_0, 16'hFFFF, 16'h0000);
        add_row(REQ_SET_PERIOD, CH_FREE_1, 16'd1, 16'h0000);
        add_row(REQ_SET_AMP, CH_FREE_0, 16'd0, 16'h8001);
        add_row(REQ_TICK, 4'd15, 16'hFFFF, 16'hFFFF);
        add_row(REQ_SET_PERIOD, 4'd15, 16'd5, 16'h0000);
        add_row(REQ_SET_AMP, 4'd9, 16'd0, 16'd123);
        add_cfg_row(1'b0);
        add_row(REQ_TICK, 4'd0, 16'd0, 16'h0000);
        add_row(REQ_ZERO_PHASE, 4'd0, 16'd0, 16'h0000);
        add_row(REQ_TICK, 4'd0, 16'd0, 16'h0000);
        add_row(REQ_TICK, 4'd0, 16'd0, 16'h0000);
    endtask

    // Draws and sends one request; returns 1 when the block acts on it.
    task automatic random_request(output bit effective);
        req_t rq;
        logic [3:0] c;
        logic [15:0] per;
        logic [15:0] amp;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            rq = REQ_TICK;
        else if (pick < 76)
            rq = REQ_SET_PERIOD;
        else if (pick < 97)
            rq = REQ_SET_AMP;
        else
            rq = REQ_ZERO_PHASE;
        if (rq == REQ_TICK || $urandom_range(0, 9) == 0)
            c = 4'($urandom_range(0, 15));
        else
            c = 4'($urandom_range(0, N_CHANNELS - 1));
        case ($urandom_range(0, 9))
            0:       per = '0;
            1:       per = 16'($urandom);
            2, 3:    per = 16'($urandom_range(65, 4096));
            default: per = 16'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 9))
            0:       amp = 16'h8000;
            1:       amp = 16'h7FFF;
            2:       amp = 16'h8001;
            3:       amp = 16'h0000;
            default: amp = 16'($urandom);
        endcase
        if (rq == REQ_TICK)
            effective = gen_enable;
        else if (rq == REQ_ZERO_PHASE)
            effective = 1'b1;
        else
            effective = (c < N_CHANNELS);
        send_request(rq, c, per, amp, 1'b0, '0);
    endtask

    initial
    begin
        int accepted;
        int phase;
        int phase_len;
        bit effective;
        rst_n = 1'b0;
        start = 1'b0;
        req_type = REQ_TICK;
        channel = '0;
        period_value = '0;
        amp_value = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        steady_phase = 1'b0;
        reset_channels();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        settle_and_configure(1'b1);

        build_directed();
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                settle_and_configure(directed_rows[i].per[0]);
            else
            begin
                send_request(directed_rows[i].req, directed_rows[i].ch, directed_rows[i].per,
                             directed_rows[i].amp, directed_rows[i].typed,
                             directed_rows[i].want);
                maybe_pause();
            end
        end

        accepted = 0;
        phase = 0;
        while (accepted < RANDOM_ITEMS)
        begin
            settle_and_configure(phase % 3 != 1);
            steady_phase = (phase % 4 == 2);
            phase_len = $urandom_range(40, 120);
            for (int n = 0; n < phase_len; n++)
            begin
                random_request(effective);
                if (effective)
                    accepted++;
                maybe_pause();
            end
            phase++;
        end

        start <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
